/* src/scfsa_pkg.sv */
package scfsa_pkg;

    // Sizing of the allocator
    localparam int NUM_CLASSES    = 17;
    localparam int STACK_DEPTH    = 1024;
    localparam int MAX_CHUNKS     = 16;
    localparam int MIN_CHUNK_LOG2 = 20;
    localparam int MAX_CHUNK_LOG2 = 30;

    // Fixed geometry of sizes and handles
    localparam int QWORD_BITS      = 3;
    localparam int PAGE_BITS       = 12;
    localparam int SLOT_BITS       = 18;
    localparam int CHUNK_BITS      = 4;
    localparam int SIZE_W          = 32;
    localparam int QW_W            = 30;
    localparam int CLS_W           = 5;
    localparam int OUTCOME_W       = 4;
    localparam int LIVE_W          = 32;
    localparam int SEG_W           = 5;
    localparam int WIN_LOW_SHIFT   = 3;
    localparam int WIN_HIGH_SHIFT  = 4;
    localparam int FIRST_CHUNK_OFS = PAGE_BITS + 1;
    localparam int HANDLE_W        = CHUNK_BITS + SLOT_BITS;

    // Stream payload widths
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 64;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = SEG_W;

    // Derived state widths
    localparam int NCL_MAX0 = (MAX_CHUNK_LOG2 > PAGE_BITS + NUM_CLASSES) ?
                              MAX_CHUNK_LOG2 : PAGE_BITS + NUM_CLASSES;
    localparam int NCL_MAX  = (NCL_MAX0 > MIN_CHUNK_LOG2) ? NCL_MAX0 : MIN_CHUNK_LOG2;
    localparam int NCL_W    = $clog2(NCL_MAX + 1);
    localparam int TOP_W    = $clog2(STACK_DEPTH + 1);
    localparam int RES_W    = SLOT_BITS + 1;
    localparam int CT_W     = $clog2(MAX_CHUNKS + 1);
    localparam int CS_AW    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int STK_DEPTH_ALL = NUM_CLASSES * STACK_DEPTH;
    localparam int STK_AW   = $clog2(STK_DEPTH_ALL);

    typedef enum logic [OUTCOME_W-1:0] {
        OC_REUSED      = 4'd0,
        OC_FRESH       = 4'd1,
        OC_FALLBACK    = 4'd2,
        OC_NULL        = 4'd3,
        OC_REFUSED     = 4'd4,
        OC_PUSHED      = 4'd5,
        OC_GEN_RELEASE = 4'd6,
        OC_IGNORED     = 4'd7,
        OC_STACK_FULL  = 4'd8,
        OC_NO_CHUNK    = 4'd9
    } t_outcome;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEGMENT_LOG2 = 1'b0,
        CFG_BLOCK_NEW    = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [LIVE_W-1:0] live;
        logic [CT_W-1:0]   chunks;
        logic [NCL_W-1:0]  next_log2;
        logic [RES_W-1:0]  reserved;
        logic [TOP_W-1:0]  top;
    } t_class_state;

    localparam int CS_W = $bits(t_class_state);

    function automatic t_class_state class_reset(input logic [CS_AW-1:0] cls);
        t_class_state r;
        int           base;
        r    = '0;
        base = FIRST_CHUNK_OFS + int'(cls);
        r.next_log2 = NCL_W'((base > MIN_CHUNK_LOG2) ? base : MIN_CHUNK_LOG2);
        return r;
    endfunction

    // Bit position of a one-hot word (OR of the indexes of set bits)
    function automatic logic [4:0] onehot_index(input logic [SIZE_W-1:0] v);
        logic [4:0] k;
        k = '0;
        for (int i = 0; i < SIZE_W; i++) begin
            if (v[i]) begin
                k = k | 5'(i);
            end
        end
        return k;
    endfunction

endpackage

/* src/scfsa_ram.sv */
module scfsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

/* src/size_class_free_stack_allocator.sv */
// Size-class allocator with one free-handle stack per class.
// Input channel s_axis: one request per item, opcode in tuser (0 allocate,
// 1 release), size and the handle being released in tdata.
// Output channel m_axis: exactly one result per request, outcome in tuser,
// class, handle and fallback quadword count in tdata.
// Configuration: i_cfg_we / i_cfg_index / i_cfg_data, write only, while idle.
// Sequence: the item is decoded at acceptance and its class record is read from
// the class table RAM; the class-record state then forms the result into the
// output register. An item that pops a reused handle goes on to a pop state,
// since the pop needs a second read of the free-handle RAM after the class record.
// The next item is accepted in the cycle after the result is registered.
// Reset clears the valid bits of the class table, so every class reads as its
// reset record at once; no clearing pass is run. The free-handle RAM is not
// initialized and only read below the stack top.
// When the receiver stalls, one result waits in the output register while the
// next item is accepted and decoded; it then holds before writing any state.
module size_class_free_stack_allocator
    import scfsa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // object_size[31:0], release_chunk[35:32], release_slot[53:36], zero pad
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // opcode[0]
    input  logic [0:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // size_class[4:0], chunk_number[8:5], slot_index[26:9],
    // qword_count[56:27], zero pad
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // outcome[3:0]
    output logic [OUTCOME_W-1:0]  m_axis_tuser
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_STATE = 3'b010,
        S_POP   = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [SEG_W-1:0] r_seg_log2;
    logic             r_block_new;

    // request registers
    logic                  r_op;
    logic                  r_is_class;
    t_outcome              r_imm;
    logic [QW_W-1:0]       r_qw;
    logic [CS_AW-1:0]      r_cls;
    logic [CHUNK_BITS-1:0] r_rchunk;
    logic [SLOT_BITS-1:0]  r_rslot;

    logic [NUM_CLASSES-1:0] r_cs_valid;

    // output register
    logic                  r_out_valid;
    t_outcome              r_out_outcome;
    logic [CLS_W-1:0]      r_out_cls;
    logic [CHUNK_BITS-1:0] r_out_chunk;
    logic [SLOT_BITS-1:0]  r_out_slot;
    logic [QW_W-1:0]       r_out_qw;

    // ------------------------------------------------------------ decode
    logic                  accept;
    logic [SIZE_W-1:0]     in_size;
    logic [SIZE_W-1:0]     size_m1;
    logic                  in_op;
    logic                  is_zero;
    logic                  is_pow2;
    logic                  is_large;
    logic [4:0]            size_log2;
    logic [6:0]            k7;
    logic [6:0]            s7;
    logic                  in_window;
    logic                  in_class_ok;
    logic [CS_AW-1:0]      in_cls;
    logic [SIZE_W:0]       qw_sum;
    logic [QW_W-1:0]       in_qw;
    t_outcome              in_imm;
    logic [QW_W-1:0]       in_imm_qw;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign in_size   = s_axis_tdata[SIZE_W-1:0];
    assign in_op     = s_axis_tuser[0];
    assign size_m1   = in_size - SIZE_W'(1);
    assign is_zero   = (in_size == '0);
    assign is_pow2   = ((in_size & size_m1) == '0);
    // rank((size-1)>>3) reaches the first page class exactly above half a page
    assign is_large  = (in_size > SIZE_W'(1 << (PAGE_BITS - 1)));
    assign size_log2 = onehot_index(in_size);
    assign k7        = {2'b00, size_log2};
    assign s7        = {2'b00, r_seg_log2};
    assign in_window = (k7 + 7'(WIN_LOW_SHIFT) >= s7) && (k7 <= s7 + 7'(WIN_HIGH_SHIFT));
    assign in_class_ok = !is_zero && is_pow2 && (size_log2 >= 5'(PAGE_BITS)) && in_window
                         && ((k7 - 7'(PAGE_BITS)) < 7'(NUM_CLASSES));
    assign in_cls    = in_class_ok ? CS_AW'(size_log2 - 5'(PAGE_BITS)) : '0;
    assign qw_sum    = {1'b0, in_size} + (SIZE_W + 1)'(7);
    assign in_qw     = qw_sum[SIZE_W:QWORD_BITS];

    always_comb begin
        in_imm_qw = '0;
        if (is_zero) begin
            in_imm = in_op ? OC_IGNORED : OC_NULL;
        end else if (!in_op && r_block_new && is_large) begin
            in_imm = OC_REFUSED;
        end else begin
            in_imm    = in_op ? OC_GEN_RELEASE : OC_FALLBACK;
            in_imm_qw = in_qw;
        end
    end

    // ------------------------------------------------------------ memories
    logic [CS_W-1:0]     cs_rdata;
    logic                cs_we;
    t_class_state        cur;
    t_class_state        n_cs;
    logic                stk_we;
    logic                stk_re;
    logic [STK_AW-1:0]   stk_base;
    logic [STK_AW-1:0]   stk_waddr;
    logic [STK_AW-1:0]   stk_raddr;
    logic [HANDLE_W-1:0] stk_rdata;

    scfsa_ram #(
        .WIDTH (CS_W),
        .DEPTH (NUM_CLASSES)
    ) u_class_ram (
        .i_clk   (i_clk),
        .i_we    (cs_we),
        .i_waddr (r_cls),
        .i_wdata (n_cs),
        .i_re    (accept),
        .i_raddr (in_cls),
        .o_rdata (cs_rdata)
    );

    scfsa_ram #(
        .WIDTH (HANDLE_W),
        .DEPTH (STK_DEPTH_ALL)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata ({r_rchunk, r_rslot}),
        .i_re    (stk_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    // an entry never written reads as its reset record
    assign cur       = r_cs_valid[r_cls] ? t_class_state'(cs_rdata) : class_reset(r_cls);
    assign stk_base  = STK_AW'(int'(r_cls) * STACK_DEPTH);
    assign stk_waddr = stk_base + STK_AW'(cur.top);
    assign stk_raddr = stk_base + STK_AW'(cur.top - TOP_W'(1));

    // ------------------------------------------------------------ new chunk size
    logic [NCL_W+1:0] chunk_diff;
    logic             slots_sat;
    logic [RES_W-1:0] new_slots;

    assign chunk_diff = {2'b00, cur.next_log2} - (NCL_W + 2)'(PAGE_BITS + int'(r_cls));
    assign slots_sat  = chunk_diff[NCL_W+1] || (chunk_diff >= (NCL_W + 2)'(SLOT_BITS));
    assign new_slots  = slots_sat ? (RES_W'(1) << SLOT_BITS) : (RES_W'(1) << chunk_diff);

    // ------------------------------------------------------------ sequencer
    logic                  out_free;
    logic                  out_load;
    logic                  fin;
    logic                  wr_cs;
    logic                  wr_stk;
    t_outcome              res_outcome;
    logic [CLS_W-1:0]      res_cls;
    logic [CHUNK_BITS-1:0] res_chunk;
    logic [SLOT_BITS-1:0]  res_slot;
    logic [QW_W-1:0]       res_qw;

    assign out_free = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state     = r_state;
        n_cs        = cur;
        fin         = 1'b0;
        wr_cs       = 1'b0;
        wr_stk      = 1'b0;
        stk_re      = 1'b0;
        res_outcome = r_imm;
        res_cls     = '0;
        res_chunk   = '0;
        res_slot    = '0;
        res_qw      = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_STATE;
                end
            end
            S_STATE: begin
                if (!r_is_class) begin
                    fin    = 1'b1;
                    res_qw = r_qw;
                end else if (r_op) begin
                    fin     = 1'b1;
                    res_cls = CLS_W'(r_cls);
                    if (cur.top >= TOP_W'(STACK_DEPTH)) begin
                        res_outcome = OC_STACK_FULL;
                    end else begin
                        res_outcome = OC_PUSHED;
                        n_cs.top    = cur.top + TOP_W'(1);
                        n_cs.live   = cur.live - LIVE_W'(1);
                        wr_cs       = 1'b1;
                        wr_stk      = 1'b1;
                    end
                end else if (cur.top != '0) begin
                    // fetch the handle below the top; the pop state finishes the request
                    stk_re  = 1'b1;
                    n_state = S_POP;
                end else if (cur.reserved == '0) begin
                    fin     = 1'b1;
                    res_cls = CLS_W'(r_cls);
                    if (cur.chunks >= CT_W'(MAX_CHUNKS)) begin
                        res_outcome = OC_NO_CHUNK;
                    end else begin
                        res_outcome   = OC_FRESH;
                        n_cs.reserved = new_slots - RES_W'(1);
                        if (cur.next_log2 < NCL_W'(MAX_CHUNK_LOG2)) begin
                            n_cs.next_log2 = cur.next_log2 + NCL_W'(1);
                        end
                        n_cs.chunks = cur.chunks + CT_W'(1);
                        n_cs.live   = cur.live + LIVE_W'(1);
                        res_chunk   = CHUNK_BITS'(cur.chunks);
                        res_slot    = SLOT_BITS'(new_slots - RES_W'(1));
                        wr_cs       = 1'b1;
                    end
                end else begin
                    fin           = 1'b1;
                    res_cls       = CLS_W'(r_cls);
                    res_outcome   = OC_FRESH;
                    n_cs.reserved = cur.reserved - RES_W'(1);
                    n_cs.live     = cur.live + LIVE_W'(1);
                    res_chunk     = CHUNK_BITS'(cur.chunks - CT_W'(1));
                    res_slot      = SLOT_BITS'(cur.reserved - RES_W'(1));
                    wr_cs         = 1'b1;
                end
            end
            S_POP: begin
                fin         = 1'b1;
                wr_cs       = 1'b1;
                res_cls     = CLS_W'(r_cls);
                res_outcome = OC_REUSED;
                res_chunk   = stk_rdata[HANDLE_W-1:SLOT_BITS];
                res_slot    = stk_rdata[SLOT_BITS-1:0];
                n_cs.top    = cur.top - TOP_W'(1);
                n_cs.live   = cur.live + LIVE_W'(1);
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // hold everything until the output register can take the result
        if (fin && out_free) begin
            n_state = S_IDLE;
        end
    end

    assign out_load = fin && out_free;
    assign cs_we    = wr_cs && out_load;
    assign stk_we   = wr_stk && out_load;

    // ------------------------------------------------------------ registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seg_log2  <= SEG_W'(16);
            r_block_new <= 1'b0;
            r_cs_valid  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_SEGMENT_LOG2: r_seg_log2  <= i_cfg_data[SEG_W-1:0];
                    CFG_BLOCK_NEW:    r_block_new <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (cs_we) begin
                r_cs_valid[r_cls] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= in_op;
            r_is_class <= in_class_ok && !(is_large && !in_op && r_block_new);
            r_imm      <= in_imm;
            r_qw       <= in_imm_qw;
            r_cls      <= in_cls;
            r_rchunk   <= s_axis_tdata[SIZE_W+CHUNK_BITS-1:SIZE_W];
            r_rslot    <= s_axis_tdata[SIZE_W+CHUNK_BITS+SLOT_BITS-1:SIZE_W+CHUNK_BITS];
        end
        if (out_load) begin
            r_out_outcome <= res_outcome;
            r_out_cls     <= res_cls;
            r_out_chunk   <= res_chunk;
            r_out_slot    <= res_slot;
            r_out_qw      <= res_qw;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_outcome;
    assign m_axis_tdata  = {(M_TDATA_W - CLS_W - CHUNK_BITS - SLOT_BITS - QW_W)'(0),
                            r_out_qw, r_out_slot, r_out_chunk, r_out_cls};

    // ------------------------------------------------------------ checks
    a_push_only_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stk_we |-> (r_op && r_is_class))
        else $error("free stack written by a request that is not a class release");

    a_pop_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stk_re |=> (r_state == S_POP) && !r_op)
        else $error("handle read not followed by the pop step");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> (cur.top != '0))
        else $error("pop from an empty free stack");

    a_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cs_we |-> (n_cs.top <= TOP_W'(STACK_DEPTH)))
        else $error("stack top written beyond the stack depth");

endmodule
